>>> rtl/trbq_pkg.sv
package trbq_pkg;

  // result field widths
  localparam int QUEUED_W = 11;

  // most bytes one poll may take (twenty result words)
  localparam logic [7:0] MAX_POLL_BYTES = 8'd160;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  // classified item as handed to the execution side
  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic        burst_start;
    logic [63:0] stamp;
    logic [7:0]  max_bytes;
  } cmd_t;

  // head of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

endpackage

>>> rtl/trbq_ifs.sv
interface trbq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        burst_start;
  logic [63:0] due_time;
  logic        apply_latency;
  logic [63:0] now_time;
  logic [7:0]  max_bytes;

  modport source (
    output valid, op, data_byte, burst_start, due_time, apply_latency, now_time, max_bytes,
    input  ready
  );
  modport sink (
    input  valid, op, data_byte, burst_start, due_time, apply_latency, now_time, max_bytes,
    output ready
  );
endinterface

interface trbq_out_if;
  import trbq_pkg::*;
  logic                valid;
  logic                ready;
  logic [63:0]         data_word;
  logic [3:0]          byte_count;
  logic                last;
  logic [1:0]          status;
  logic [QUEUED_W-1:0] queued_chunks;

  modport source (
    output valid, data_word, byte_count, last, status, queued_chunks,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, last, status, queued_chunks,
    output ready
  );
endinterface

interface trbq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> rtl/trbq_front.sv
module trbq_front (
  input  logic            clk,
  input  logic            rst_n,
  trbq_in_if.sink         in_ch,
  trbq_cfg_if.sink        cfg_ch,
  input  logic            cmdq_full,
  output logic            cmdq_push,
  output trbq_pkg::cmd_t  cmdq_wdata
);
  import trbq_pkg::*;

  logic [31:0] latency_r;

  // delivery latency register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      latency_r <= cfg_ch.data;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // take an item whenever the queue has room
  assign in_ch.ready = !cmdq_full;
  assign cmdq_push   = in_ch.valid && in_ch.ready;

  // classify: pick the time stamp and clamp the poll size
  always_comb begin
    cmdq_wdata.op          = in_ch.op;
    cmdq_wdata.data_byte   = in_ch.data_byte;
    cmdq_wdata.burst_start = in_ch.burst_start;
    if (in_ch.op == OP_POLL) begin
      cmdq_wdata.stamp = in_ch.now_time;
    end else if (in_ch.apply_latency) begin
      cmdq_wdata.stamp = in_ch.due_time + 64'(latency_r);
    end else begin
      cmdq_wdata.stamp = in_ch.due_time;
    end
    if (in_ch.max_bytes > MAX_POLL_BYTES) begin
      cmdq_wdata.max_bytes = MAX_POLL_BYTES;
    end else begin
      cmdq_wdata.max_bytes = in_ch.max_bytes;
    end
  end

endmodule

>>> rtl/trbq_cmd_fifo.sv
module trbq_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  trbq_pkg::cmd_t        wdata,
  output logic                  full,
  input  logic                  pop,
  output trbq_pkg::cmdq_head_t  head
);
  import trbq_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   count_r;

  assign full       = (count_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/trbq_back.sv
module trbq_back #(
  parameter int RING_DEPTH  = 1024,
  parameter int CHUNK_BYTES = 160
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trbq_pkg::cmdq_head_t  cmdq_head,
  output logic                  cmdq_pop,
  trbq_out_if.source            out_ch
);
  import trbq_pkg::*;

  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int LEN_W      = $clog2(CHUNK_BYTES + 1);
  localparam int ROWS       = (CHUNK_BYTES + 7) / 8;
  localparam int LANE_DEPTH = RING_DEPTH * ROWS + 1;
  localparam int LANE_AW    = $clog2(LANE_DEPTH);
  localparam int CMP_W      = 9;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_RDW  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               tail_open_r, tail_open_nxt;
  logic [IDX_W-1:0]   tail_idx_r, tail_idx_nxt;
  logic [LANE_AW-1:0] tail_base_r, tail_base_nxt;
  logic [LEN_W-1:0]   tail_len_r, tail_len_nxt;
  cmd_t               cur_r, cur_nxt;
  logic [LANE_AW-1:0] srv_base_r, srv_base_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;

  // output register
  logic                out_valid_r;
  logic [63:0]         out_word_r;
  logic [3:0]          out_cnt_r;
  logic                out_last_r;
  logic [1:0]          out_status_r;
  logic [QUEUED_W-1:0] out_queued_r;
  logic                out_load;
  logic [63:0]         emit_word;
  logic [3:0]          emit_cnt;
  logic                emit_last;
  logic [1:0]          emit_status;
  logic [CNT_W-1:0]    emit_queued;
  logic                slot_free;

  // chunk metadata memories
  logic [63:0]        due_mem [RING_DEPTH];
  logic [LEN_W-1:0]   len_mem [RING_DEPTH];
  logic [LEN_W-1:0]   off_mem [RING_DEPTH];
  logic [63:0]        rd_due_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic [LEN_W-1:0]   rd_off_r;
  logic               due_we;
  logic               len_we;
  logic               off_we;
  logic [IDX_W-1:0]   len_waddr;
  logic [LEN_W-1:0]   len_wdata;
  logic [IDX_W-1:0]   off_waddr;
  logic [LEN_W-1:0]   off_wdata;

  // byte lane write port
  logic               byte_we;
  logic [2:0]         byte_lane;
  logic [LANE_AW-1:0] byte_row;
  wire  [63:0]        lanes_cat;

  // push decode
  logic               need_new;
  logic               ring_full;
  logic [CNT_W:0]     tail_sum;
  logic [IDX_W-1:0]   new_tail;
  logic [LANE_AW-1:0] new_base;
  logic [IDX_W-1:0]   head_inc;

  // poll decode
  logic               not_due;
  logic [LEN_W-1:0]   avail;
  logic [LEN_W-1:0]   n_serve;
  logic [LEN_W-1:0]   new_off;
  logic               retire;
  logic [CNT_W-1:0]   total_after;
  logic [127:0]       lanes_dbl;
  logic [63:0]        word_rot;

  assign slot_free = !out_valid_r || out_ch.ready;

  // where a pushed byte goes
  assign need_new  = cmdq_head.cmd.burst_start || !tail_open_r || (total_r == '0) ||
                     (tail_len_r >= LEN_W'(CHUNK_BYTES));
  assign ring_full = (total_r >= CNT_W'(RING_DEPTH));
  assign tail_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(total_r);
  assign new_tail  = (tail_sum >= (CNT_W + 1)'(RING_DEPTH)) ?
                     IDX_W'(tail_sum - (CNT_W + 1)'(RING_DEPTH)) : IDX_W'(tail_sum);
  assign new_base  = LANE_AW'(new_tail) * LANE_AW'(ROWS);
  assign head_inc  = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // head chunk check and serve size
  assign not_due     = (total_r == '0) || (rd_due_r > cur_r.stamp) || (cur_r.max_bytes == '0);
  assign avail       = (rd_len_r > rd_off_r) ? rd_len_r - rd_off_r : '0;
  assign n_serve     = (CMP_W'(avail) < CMP_W'(cur_r.max_bytes)) ? avail :
                       LEN_W'(cur_r.max_bytes);
  assign new_off     = rd_off_r + n_serve;
  assign retire      = (new_off >= rd_len_r);
  assign total_after = retire ? total_r - 1'b1 : total_r;

  // align the eight lanes to the read position and blank unused bytes
  assign lanes_dbl = {lanes_cat, lanes_cat};
  assign word_rot  = lanes_dbl[{pos_r[2:0], 3'b000} +: 64];

  always_comb begin
    emit_cnt = (rem_r >= LEN_W'(8)) ? 4'd8 : 4'(rem_r);
    for (int b = 0; b < 8; b++) begin
      emit_word[8*b +: 8] = (4'(b) < emit_cnt) ? word_rot[8*b +: 8] : 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    tail_open_nxt = tail_open_r;
    tail_idx_nxt  = tail_idx_r;
    tail_base_nxt = tail_base_r;
    tail_len_nxt  = tail_len_r;
    cur_nxt       = cur_r;
    srv_base_nxt  = srv_base_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    cmdq_pop      = 1'b0;
    out_load      = 1'b0;
    emit_last     = 1'b1;
    emit_status   = STATUS_OK;
    emit_queued   = total_r;
    due_we        = 1'b0;
    len_we        = 1'b0;
    off_we        = 1'b0;
    len_waddr     = tail_idx_r;
    len_wdata     = tail_len_r + 1'b1;
    off_waddr     = new_tail;
    off_wdata     = '0;
    byte_we       = 1'b0;
    byte_lane     = tail_len_r[2:0];
    byte_row      = tail_base_r + LANE_AW'(tail_len_r[LEN_W-1:3]);

    unique case (state_r)
      S_IDLE: begin
        if (cmdq_head.valid) begin
          if (cmdq_head.cmd.op == OP_PUSH) begin
            if (slot_free) begin
              cmdq_pop = 1'b1;
              out_load = 1'b1;
              if (need_new && ring_full) begin
                tail_open_nxt = 1'b0;
                emit_status   = STATUS_DROP;
              end else if (need_new) begin
                due_we        = 1'b1;
                len_we        = 1'b1;
                off_we        = 1'b1;
                len_waddr     = new_tail;
                len_wdata     = LEN_W'(1);
                byte_we       = 1'b1;
                byte_lane     = '0;
                byte_row      = new_base;
                tail_idx_nxt  = new_tail;
                tail_base_nxt = new_base;
                tail_len_nxt  = LEN_W'(1);
                total_nxt     = total_r + 1'b1;
                tail_open_nxt = 1'b1;
                emit_queued   = total_r + 1'b1;
              end else begin
                len_we       = 1'b1;
                byte_we      = 1'b1;
                tail_len_nxt = tail_len_r + 1'b1;
              end
            end
          end else begin
            cmdq_pop  = 1'b1;
            cur_nxt   = cmdq_head.cmd;
            state_nxt = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        if (slot_free) begin
          if (not_due) begin
            out_load    = 1'b1;
            emit_status = STATUS_NONE;
            state_nxt   = S_IDLE;
          end else begin
            off_we    = 1'b1;
            off_waddr = head_r;
            off_wdata = new_off;
            if (retire) begin
              head_nxt  = head_inc;
              total_nxt = total_after;
              if (total_after == '0) begin
                tail_open_nxt = 1'b0;
              end
            end
            if (n_serve == '0) begin
              out_load    = 1'b1;
              emit_status = STATUS_NONE;
              emit_queued = total_after;
              state_nxt   = S_IDLE;
            end else begin
              srv_base_nxt = LANE_AW'(head_r) * LANE_AW'(ROWS);
              pos_nxt      = rd_off_r;
              rem_nxt      = n_serve;
              state_nxt    = S_RDW;
            end
          end
        end
      end

      S_RDW: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          emit_last = (rem_r <= LEN_W'(8));
          if (rem_r <= LEN_W'(8)) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + LEN_W'(8);
            rem_nxt   = rem_r - LEN_W'(8);
            state_nxt = S_RDW;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      total_r     <= '0;
      tail_open_r <= 1'b0;
      tail_len_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      tail_open_r <= tail_open_nxt;
      tail_len_r  <= tail_len_nxt;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    tail_idx_r  <= tail_idx_nxt;
    tail_base_r <= tail_base_nxt;
    cur_r       <= cur_nxt;
    srv_base_r  <= srv_base_nxt;
    pos_r       <= pos_nxt;
    rem_r       <= rem_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r   <= (state_r == S_EMIT) ? emit_word : 64'h0;
      out_cnt_r    <= (state_r == S_EMIT) ? emit_cnt : 4'd0;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
      out_queued_r <= QUEUED_W'(emit_queued);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_word     = out_word_r;
  assign out_ch.byte_count    = out_cnt_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.queued_chunks = out_queued_r;

  // chunk due time memory, stamp of the push that opens the chunk
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[new_tail] <= cmdq_head.cmd.stamp;
    end
    rd_due_r <= due_mem[head_r];
  end

  // chunk length memory
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    rd_len_r <= len_mem[head_r];
  end

  // chunk read offset memory
  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    rd_off_r <= off_mem[head_r];
  end

  // byte storage, one memory per byte lane of a result word
  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [7:0]         mem [LANE_DEPTH];
    logic [7:0]         rd_r;
    logic [LANE_AW-1:0] rd_row;

    assign rd_row = srv_base_r + LANE_AW'(pos_r[LEN_W-1:3]) +
                    LANE_AW'(3'(l) < pos_r[2:0]);

    always_ff @(posedge clk) begin
      if (byte_we && (byte_lane == 3'(l))) begin
        mem[byte_row] <= cmdq_head.cmd.data_byte;
      end
      rd_r <= mem[rd_row];
    end

    assign lanes_cat[8*l +: 8] = rd_r;
  end

endmodule

>>> rtl/timed_burst_release_queue_unit.sv
// Timed burst release queue. Push items append one byte each to a ring of up
// to RING_DEPTH chunks of up to CHUNK_BYTES bytes, each chunk stamped with a
// release time; poll items drain the head chunk once its time has come, eight
// bytes to a result word. Items enter a four-entry command queue, so in_ch
// keeps accepting until that queue is full, while the execution side is busy
// or out_ch is stalled. On the execution side a push is handled in S_IDLE; a
// poll checks the head chunk in S_EVAL, then goes through S_RDW, the
// registered read of the eight byte-lane memories, and S_EMIT for each
// result word. Every item gives at least one result. No clearing pass is
// run after reset: chunk storage is only read where it has been written.
// delivery_latency may only be written while no item is in flight.
module timed_burst_release_queue_unit #(
  parameter int RING_DEPTH  = 1024,
  parameter int CHUNK_BYTES = 160
) (
  input  logic         clk,
  input  logic         rst_n,
  trbq_in_if.sink      in_ch,
  trbq_out_if.source   out_ch,
  trbq_cfg_if.sink     cfg_ch
);
  import trbq_pkg::*;

  cmd_t       cmdq_wdata;
  logic       cmdq_push;
  logic       cmdq_full;
  logic       cmdq_pop;
  cmdq_head_t cmdq_head;

  // intake and classification
  trbq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .cmdq_full  (cmdq_full),
    .cmdq_push  (cmdq_push),
    .cmdq_wdata (cmdq_wdata)
  );

  // decoupling queue
  trbq_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmdq_push),
    .wdata (cmdq_wdata),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .head  (cmdq_head)
  );

  // chunk ring and release logic
  trbq_back #(
    .RING_DEPTH  (RING_DEPTH),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmdq_head (cmdq_head),
    .cmdq_pop  (cmdq_pop),
    .out_ch    (out_ch)
  );

endmodule
